@@ rtl/core/fixed_block_allocator_unit_defines.svh @@
// Assertion macros for the fixed block allocator.
`ifndef FIXED_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define FBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Next-cycle implication built on the clocked assertion.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
   `FBA_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/core/fba_pkg.sv @@
// Package for the fixed block allocator: constants, payload and control types.
package fba_pkg;

   localparam int NUM_BLOCKS  = 64;
   localparam int BLOCK_BYTES = 1024;
   localparam int WORD_BITS   = 16;
   localparam int NUM_WORDS   = NUM_BLOCKS / WORD_BITS;

   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int BIT_SEL_W  = $clog2(WORD_BITS);
   localparam int WORD_SEL_W = $clog2(NUM_WORDS);
   localparam int PTR_W      = WORD_SEL_W + 1;
   localparam int SIZE_W     = 32;
   localparam int STATUS_W   = 3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd4;

   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] request_size;
      logic [IDX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    granted_index;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic execute;
      logic scan_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic none_free;
   } dp_stat_type;

endpackage

@@ rtl/core/fba_ctrl.sv @@
// Controller state machine for the fixed block allocator.
module fba_ctrl
   import fba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      FSM_IDLE = 4'b0001,
      FSM_EXEC = 4'b0010,
      FSM_SCAN = 4'b0100,
      FSM_RESP = 4'b1000
   } fsm_type;

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = stat.need_scan ? FSM_SCAN : FSM_RESP;
         end
         FSM_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = FSM_RESP;
            end
         end
         FSM_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/fba_datapath.sv @@
// Datapath for the fixed block allocator: marks, hint, word scan and result.
module fba_datapath
   import fba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   input  req_type          req_data,
   output rsp_type          rsp_data,
   input  dp_cmd_type       cmd,
   output dp_stat_type      stat
);

   logic [NUM_BLOCKS-1:0] marks_ff, marks_in;
   logic [IDX_W-1:0]      hint_ff, hint_in;
   logic                  none_free_ff, none_free_in;
   logic [CNT_W-1:0]      pool_ff, pool_in;
   logic [PTR_W-1:0]      scan_ptr_ff, scan_ptr_in;
   req_type               req_ff, req_in;
   rsp_type               result_ff, result_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CNT_W-1:0]      count;
   logic [IDX_W-1:0]      count_m1;
   logic [WORD_SEL_W-1:0] last_word;
   logic                  too_large;
   logic                  pool_full;
   logic                  bad_index;
   logic                  is_marked;
   logic                  alloc_ok;
   logic [CNT_W-1:0]      next_start;
   logic [WORD_BITS-1:0]  word_bits;
   logic [WORD_BITS-1:0]  cand;
   logic [BIT_SEL_W-1:0]  enc;
   logic                  found;
   logic                  past_last;
   logic [IDX_W-1:0]      found_idx;

   // pool size clamped to 1..NUM_BLOCKS
   always_comb begin
      if (pool_ff == '0) begin
         count = CNT_W'(1);
      end else if (pool_ff > CNT_W'(NUM_BLOCKS)) begin
         count = CNT_W'(NUM_BLOCKS);
      end else begin
         count = pool_ff;
      end
   end

   assign count_m1  = IDX_W'(count - CNT_W'(1));
   assign last_word = count_m1[IDX_W-1:BIT_SEL_W];

   assign too_large  = req_ff.request_size > SIZE_W'(BLOCK_BYTES);
   assign pool_full  = none_free_ff || ({1'b0, hint_ff} >= count);
   assign bad_index  = {1'b0, req_ff.block_index} >= count;
   assign is_marked  = marks_ff[req_ff.block_index];
   assign alloc_ok   = (req_ff.mode == MODE_ALLOC) && !too_large && !pool_full;
   assign next_start = {1'b0, hint_ff} + CNT_W'(1);

   // one bitmap word per scan step
   assign word_bits = marks_ff[scan_ptr_ff[WORD_SEL_W-1:0] * WORD_BITS +: WORD_BITS];

   always_comb begin
      logic [IDX_W-1:0] gidx;
      for (int b = 0; b < WORD_BITS; b++) begin
         gidx    = {scan_ptr_ff[WORD_SEL_W-1:0], BIT_SEL_W'(b)};
         cand[b] = !word_bits[b] && (gidx > result_ff.granted_index)
                   && ({1'b0, gidx} < count);
      end
   end

   always_comb begin
      enc = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            enc = BIT_SEL_W'(b);
         end
      end
   end

   assign found     = |cand;
   assign past_last = scan_ptr_ff >= {1'b0, last_word};
   assign found_idx = {scan_ptr_ff[WORD_SEL_W-1:0], enc};

   always_comb begin
      marks_in     = marks_ff;
      hint_in      = hint_ff;
      none_free_in = none_free_ff;
      pool_in      = pool_ff;
      scan_ptr_in  = scan_ptr_ff;
      req_in       = req_ff;
      result_in    = result_ff;
      rsp_in       = rsp_ff;

      if (csr_write_enable) begin
         pool_in      = csr_write_data;
         marks_in     = '0;
         hint_in      = '0;
         none_free_in = 1'b0;
      end else if (cmd.execute) begin
         result_in.status        = ST_OK;
         result_in.granted_index = '0;
         if (req_ff.mode == MODE_ALLOC) begin
            if (too_large) begin
               result_in.status = ST_TOO_LARGE;
            end else if (pool_full) begin
               result_in.status = ST_POOL_FULL;
            end else begin
               marks_in[hint_ff]       = 1'b1;
               result_in.granted_index = hint_ff;
               scan_ptr_in             = next_start[CNT_W-1:BIT_SEL_W];
            end
         end else begin
            if (bad_index) begin
               result_in.status = ST_BAD_INDEX;
            end else if (!is_marked) begin
               result_in.status = ST_DOUBLE_FREE;
            end else begin
               marks_in[req_ff.block_index] = 1'b0;
               if (none_free_ff || (req_ff.block_index < hint_ff)) begin
                  hint_in      = req_ff.block_index;
                  none_free_in = 1'b0;
               end
            end
         end
      end else if (cmd.scan_step) begin
         if (found) begin
            hint_in = found_idx;
         end else if (past_last) begin
            none_free_in = 1'b1;
            hint_in      = '0;
         end else begin
            scan_ptr_in = scan_ptr_ff + PTR_W'(1);
         end
      end

      if (cmd.load_req) begin
         req_in = req_data;
      end
      if (cmd.load_rsp) begin
         rsp_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff     <= '0;
         hint_ff      <= '0;
         none_free_ff <= 1'b0;
         pool_ff      <= CNT_W'(NUM_BLOCKS);
      end else begin
         marks_ff     <= marks_in;
         hint_ff      <= hint_in;
         none_free_ff <= none_free_in;
         pool_ff      <= pool_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      req_ff      <= req_in;
      result_ff   <= result_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data       = rsp_ff;
   assign stat.need_scan = alloc_ok;
   assign stat.scan_done = found || past_last;
   assign stat.none_free = none_free_ff;

endmodule

@@ rtl/core/fixed_block_allocator_unit.sv @@
// Top level of the fixed block allocator: controller, datapath and checks.
//
// Hands out and takes back fixed-size blocks from a pool of up to 64.
// Request channel (req_valid/req_stall/req_data): mode 0 allocates a block of
// up to 1024 bytes, mode 1 frees block_index. Response channel
// (rsp_valid/rsp_stall/rsp_data) returns one status and granted index per
// request, in order.
// Steps: the request is accepted and executed, and its result is loaded into
// the output register; a successful allocate first scans for the next free
// block, one 16-bit bitmap word per cycle. Requests are worked one at a time,
// so a new one is taken only after the last has been handed to the output
// register; the word scan lengthens the spacing.
// A finished response sits in an output register; while rsp_stall is high it
// holds and the next request may already be accepted and worked on.
// csr_write_data sets the pool size (clamped to 1..64) and frees every block.
// Reset frees every block, sets the pool size to 64 and the hint to block 0.
`include "fixed_block_allocator_unit_defines.svh"

module fixed_block_allocator_unit
   import fba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // pool size register
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data
);

   dp_cmd_type  ctrl_cmd;
   dp_stat_type dp_stat;

   // sequencing: accept, execute, scan, hand off
   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   // bitmap, hint and result registers
   fba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .cmd              (ctrl_cmd),
      .stat             (dp_stat)
   );

   // the block is busy the cycle after taking a request
   `FBA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "accepted request did not make block busy")

   // only a successful allocate carries a nonzero index
   `FBA_ASSERT(a_index_zero_on_error,
      rsp_valid && (rsp_data.status != ST_OK) |-> (rsp_data.granted_index == '0),
      "failed request returned a block index")

   // a pool size write frees every block, so the pool is no longer marked full
   `FBA_ASSERT_NEXT(a_csr_clears_full, csr_write_enable, !dp_stat.none_free,
      "pool still full after size write")

endmodule
